// ===== rtl/dot_product_phase_rotator_macros.svh =====
// Assertion macros for the rotator RTL, used by the output stage dpr_out.
`ifndef DOT_PRODUCT_PHASE_ROTATOR_MACROS_SVH
`define DOT_PRODUCT_PHASE_ROTATOR_MACROS_SVH

// Plain property, sampled on clk, off during reset.
`define DPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define DPR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DPR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dpr_pkg.sv =====
// Types, constants and the arctangent table of the dot-product phase rotator.
package dpr_pkg;

  localparam int VEC_W    = 24;
  localparam int PROD_W   = 2 * VEC_W;
  localparam int DOT_W    = PROD_W + 2;
  localparam int FACTOR_W = 24;
  localparam int TURNS_W  = 56;
  localparam int HALF_W   = TURNS_W / 2;
  localparam int PHASE_W  = 32;
  localparam int CW       = 34;
  localparam int OUT_W    = 16;
  localparam int ANG_TABLE_LEN = 24;

  localparam logic [FACTOR_W-1:0] PHASE_FACTOR_RST = 24'd3776207;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [CW-1:0] ROUND_HALF = 34'sd16384;
  localparam logic signed [CW-1:0] OUT_LIMIT = 34'sd32767;

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [CW-1:0]    cw_t;
  typedef logic signed [OUT_W-1:0] out_t;

  function automatic cw_t ang_lut(input int unsigned idx);
    cw_t a;
    unique case (idx)
      0:  a = 34'sd536870912;
      1:  a = 34'sd316933406;
      2:  a = 34'sd167458907;
      3:  a = 34'sd85004756;
      4:  a = 34'sd42667331;
      5:  a = 34'sd21354465;
      6:  a = 34'sd10679838;
      7:  a = 34'sd5340245;
      8:  a = 34'sd2670163;
      9:  a = 34'sd1335087;
      10: a = 34'sd667544;
      11: a = 34'sd333772;
      12: a = 34'sd166886;
      13: a = 34'sd83443;
      14: a = 34'sd41721;
      15: a = 34'sd20860;
      16: a = 34'sd10430;
      17: a = 34'sd5215;
      18: a = 34'sd2607;
      19: a = 34'sd1303;
      20: a = 34'sd651;
      21: a = 34'sd325;
      22: a = 34'sd162;
      23: a = 34'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/dpr_dot.sv =====
// Two-stage dot product of the potential and position vectors.
module dpr_dot (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                vld_in,
  input  dpr_pkg::vec_t                       pot_x,
  input  dpr_pkg::vec_t                       pot_y,
  input  dpr_pkg::vec_t                       pot_z,
  input  dpr_pkg::vec_t                       pos_x,
  input  dpr_pkg::vec_t                       pos_y,
  input  dpr_pkg::vec_t                       pos_z,
  input  logic                                negate,
  output logic                                vld_out,
  output logic signed [dpr_pkg::DOT_W-1:0]    dot,
  output logic                                neg_out
);
  import dpr_pkg::*;

  logic signed [PROD_W-1:0] p0_r, p1_r, p2_r;
  logic signed [PROD_W-1:0] p0_nxt, p1_nxt, p2_nxt;
  logic                     neg_a_r, vld_a_r;
  logic signed [DOT_W-1:0]  dot_r, dot_nxt;
  logic                     neg_b_r, vld_b_r;

  always_comb begin
    p0_nxt = PROD_W'(pot_x) * PROD_W'(pos_x);
    p1_nxt = PROD_W'(pot_y) * PROD_W'(pos_y);
    p2_nxt = PROD_W'(pot_z) * PROD_W'(pos_z);
    dot_nxt = DOT_W'(p0_r) + DOT_W'(p1_r) + DOT_W'(p2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= vld_in;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r    <= p0_nxt;
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
      neg_a_r <= negate;
      dot_r   <= dot_nxt;
      neg_b_r <= neg_a_r;
    end
  end

  assign vld_out = vld_b_r;
  assign dot     = dot_r;
  assign neg_out = neg_b_r;

endmodule

// ===== rtl/dpr_phase.sv =====
// Scaling by the phase factor, sign and quadrant reduction: three stages.
module dpr_phase (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               vld_in,
  input  logic signed [dpr_pkg::DOT_W-1:0]   dot,
  input  logic                               neg_in,
  input  logic [dpr_pkg::FACTOR_W-1:0]       factor,
  output logic                               vld_out,
  output dpr_pkg::cw_t                       z0,
  output logic                               flip
);
  import dpr_pkg::*;

  logic [TURNS_W-1:0]        dot_ext;
  logic [HALF_W+FACTOR_W-1:0] plo_nxt, phi_full;
  logic [HALF_W+FACTOR_W-1:0] plo_r;
  logic [HALF_W-1:0]         phi_r;
  logic                      neg_c_r, vld_c_r;
  logic [TURNS_W-1:0]        turns_nxt, turns_r, turns_sgn;
  logic                      neg_d_r, vld_d_r;
  logic [PHASE_W-1:0]        phase, phase_red;
  logic                      flip_nxt;
  cw_t                       z_nxt, z_r;
  logic                      flip_r, vld_e_r;

  always_comb begin
    // modulo one turn: only the low 56 bits of the product matter
    dot_ext  = {{(TURNS_W-DOT_W){dot[DOT_W-1]}}, dot};
    plo_nxt  = (HALF_W+FACTOR_W)'(dot_ext[HALF_W-1:0]) * (HALF_W+FACTOR_W)'(factor);
    phi_full = (HALF_W+FACTOR_W)'(dot_ext[TURNS_W-1:HALF_W]) * (HALF_W+FACTOR_W)'(factor);
    turns_nxt = TURNS_W'(plo_r) + {phi_r, {HALF_W{1'b0}}};
    turns_sgn = neg_d_r ? (TURNS_W'(0) - turns_r) : turns_r;
    phase     = turns_sgn[TURNS_W-1 -: PHASE_W];
    flip_nxt  = phase[PHASE_W-1] ^ phase[PHASE_W-2];
    phase_red = {phase[PHASE_W-1] ^ flip_nxt, phase[PHASE_W-2:0]};
    z_nxt     = CW'(signed'(phase_red));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
      vld_e_r <= 1'b0;
    end else if (en) begin
      vld_c_r <= vld_in;
      vld_d_r <= vld_c_r;
      vld_e_r <= vld_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r   <= plo_nxt;
      phi_r   <= phi_full[HALF_W-1:0];
      neg_c_r <= neg_in;
      turns_r <= turns_nxt;
      neg_d_r <= neg_c_r;
      z_r     <= z_nxt;
      flip_r  <= flip_nxt;
    end
  end

  assign vld_out = vld_e_r;
  assign z0      = z_r;
  assign flip    = flip_r;

endmodule

// ===== rtl/dpr_cordic.sv =====
// Rotation-mode CORDIC, one register stage per iteration.
module dpr_cordic #(
  parameter int STAGES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         vld_in,
  input  dpr_pkg::cw_t z0,
  input  logic         flip_in,
  output logic         vld_out,
  output dpr_pkg::cw_t x_out,
  output dpr_pkg::cw_t y_out,
  output logic         flip_out
);
  import dpr_pkg::*;

  localparam int NSTG = (STAGES < ANG_TABLE_LEN) ? STAGES : ANG_TABLE_LEN;

  cw_t  x_r [NSTG];
  cw_t  y_r [NSTG];
  cw_t  z_r [NSTG];
  logic f_r [NSTG];
  logic v_r [NSTG];

  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    cw_t  xi, yi, zi, x_nxt, y_nxt, z_nxt;
    logic fi, vi;

    if (i == 0) begin : g_first
      assign xi = CORDIC_X0;
      assign yi = '0;
      assign zi = z0;
      assign fi = flip_in;
      assign vi = vld_in;
    end else begin : g_rest
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign fi = f_r[i-1];
      assign vi = v_r[i-1];
    end

    always_comb begin
      if (!zi[CW-1]) begin
        x_nxt = xi - (yi >>> i);
        y_nxt = yi + (xi >>> i);
        z_nxt = zi - ang_lut(i);
      end else begin
        x_nxt = xi + (yi >>> i);
        y_nxt = yi - (xi >>> i);
        z_nxt = zi + ang_lut(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
        f_r[i] <= fi;
      end
    end
  end

  assign vld_out  = v_r[NSTG-1];
  assign x_out    = x_r[NSTG-1];
  assign y_out    = y_r[NSTG-1];
  assign flip_out = f_r[NSTG-1];

endmodule

// ===== rtl/dpr_out.sv =====
// Half-turn fix-up, Q1.15 rounding with saturation, output register and skid.
`include "dot_product_phase_rotator_macros.svh"

module dpr_out (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_in,
  input  dpr_pkg::cw_t         x_in,
  input  dpr_pkg::cw_t         y_in,
  input  logic                 flip,
  output logic                 up_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dpr_pkg::out_t        cos_part,
  output dpr_pkg::out_t        sin_part
);
  import dpr_pkg::*;

  function automatic out_t to_q15(input cw_t v);
    cw_t r;
    out_t o;
    r = (v + ROUND_HALF) >>> 15;
    if (r > OUT_LIMIT) begin
      o = OUT_W'(OUT_LIMIT);
    end else if (r < -OUT_LIMIT) begin
      o = OUT_W'(-OUT_LIMIT);
    end else begin
      o = r[OUT_W-1:0];
    end
    return o;
  endfunction

  cw_t  xf, yf;
  out_t cos_nxt, sin_nxt;
  out_t cos_r, sin_r, cos_sk_r, sin_sk_r;
  logic out_valid_r, skid_valid_r;

  always_comb begin
    xf = flip ? -x_in : x_in;
    yf = flip ? -y_in : y_in;
    cos_nxt = to_q15(xf);
    sin_nxt = to_q15(yf);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= vld_in;
      end
    end else if (vld_in && !skid_valid_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        cos_r <= cos_sk_r;
        sin_r <= sin_sk_r;
      end else begin
        cos_r <= cos_nxt;
        sin_r <= sin_nxt;
      end
    end else if (vld_in && !skid_valid_r) begin
      cos_sk_r <= cos_nxt;
      sin_sk_r <= sin_nxt;
    end
  end

  assign up_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign cos_part  = cos_r;
  assign sin_part  = sin_r;

  `DPR_ASSERT_IMP(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full with empty output")
  `DPR_ASSERT(a_no_min_code, !out_valid_r || (cos_r != 16'sh8000 && sin_r != 16'sh8000), "saturation let -32768 through")
  `DPR_ASSERT_NXT(a_skid_hold, skid_valid_r && !out_ready, skid_valid_r && $stable(cos_sk_r) && $stable(sin_sk_r), "skid item lost or changed while stalled")

endmodule

// ===== rtl/dot_product_phase_rotator.sv =====
// Dot-product phase rotator top level: register, pipeline and stream ports.
// Computes cos and sin of the phase f * (A . r), in turns modulo one turn,
// with the sign flipped when in_tuser is set; f is phase_turns_factor (Q0.24,
// written on the cfg port). Fully pipelined: one item is accepted per cycle
// while in_tready is high. Each item passes through the dot product, then scaling
// and quadrant reduction, then the CORDIC iterations, then rounding into the
// output register. A two-entry output register/skid keeps in_tready registered;
// under back-pressure the whole pipeline holds. cfg_ready is always high; write
// the factor only while idle.
module dot_product_phase_rotator #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [143:0] in_tdata,   // pot_x, pot_y, pot_z, pos_x, pos_y, pos_z
  input  logic [0:0]   in_tuser,   // negate
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // cos_part, sin_part
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [23:0]  cfg_data    // phase_turns_factor
);
  import dpr_pkg::*;

  logic [FACTOR_W-1:0]     factor_r;
  logic                    en;
  logic                    dot_vld, dot_neg;
  logic signed [DOT_W-1:0] dot;
  logic                    ph_vld, ph_flip;
  cw_t                     z0;
  logic                    cd_vld, cd_flip;
  cw_t                     cd_x, cd_y;
  out_t                    cos_part, sin_part;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= PHASE_FACTOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      factor_r <= cfg_data;
    end
  end

  assign in_tready = en;

  dpr_dot u_dot (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (in_tvalid),
    .pot_x   (in_tdata[23:0]),
    .pot_y   (in_tdata[47:24]),
    .pot_z   (in_tdata[71:48]),
    .pos_x   (in_tdata[95:72]),
    .pos_y   (in_tdata[119:96]),
    .pos_z   (in_tdata[143:120]),
    .negate  (in_tuser[0]),
    .vld_out (dot_vld),
    .dot     (dot),
    .neg_out (dot_neg)
  );

  dpr_phase u_phase (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (dot_vld),
    .dot     (dot),
    .neg_in  (dot_neg),
    .factor  (factor_r),
    .vld_out (ph_vld),
    .z0      (z0),
    .flip    (ph_flip)
  );

  dpr_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_in   (ph_vld),
    .z0       (z0),
    .flip_in  (ph_flip),
    .vld_out  (cd_vld),
    .x_out    (cd_x),
    .y_out    (cd_y),
    .flip_out (cd_flip)
  );

  dpr_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_in    (cd_vld),
    .x_in      (cd_x),
    .y_in      (cd_y),
    .flip      (cd_flip),
    .up_ready  (en),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cos_part  (cos_part),
    .sin_part  (sin_part)
  );

  assign out_tdata = {sin_part, cos_part};

endmodule
